>>> hdl/frustum_visibility_test_macros.svh
// Assertion macros for the frustum visibility test.
// FVT_ASSERT checks a property while out of reset.
// FVT_ASSERT_RST checks a property also during reset.
`ifndef FRUSTUM_VISIBILITY_TEST_MACROS_SVH
`define FRUSTUM_VISIBILITY_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define FVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FVT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FVT_ASSERT(lbl, clk, rstn, prop, msg)
`define FVT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/fvt_pkg.sv
`timescale 1ns / 1ps
package fvt_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ROT_ROW0   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_ROW1   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROT_ROW2   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CAM_CENTRE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INTRINSICS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IMG_BOUNDS = 3'd5;

  localparam logic [63:0] ROT_ROW0_RST = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ROT_ROW1_RST = 64'h0000_4000_0000_0000;
  localparam logic [63:0] ROT_ROW2_RST = 64'h0000_0000_4000_0000;

  typedef enum logic [2:0] {
    RSN_NONE  = 3'd0,
    RSN_DEPTH = 3'd1,
    RSN_OUT_X = 3'd2,
    RSN_OUT_Y = 3'd3,
    RSN_DIST  = 3'd4,
    RSN_ANGLE = 3'd5
  } reason_e;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        max_distance;
    logic signed [15:0] cos_limit;
  } point_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] reject_reason;
  } result_t;

  typedef struct packed {
    logic [63:0] rot_row0;
    logic [63:0] rot_row1;
    logic [63:0] rot_row2;
    logic [47:0] camera_centre;
    logic [63:0] intrinsics;
    logic [63:0] image_bounds;
  } cam_cfg_t;

  // camera coordinates, squares and dot terms after the transform stages
  typedef struct packed {
    logic signed [33:0] pc_x;
    logic signed [33:0] pc_y;
    logic signed [33:0] pc_z;
    logic [32:0]        sq_x;
    logic [32:0]        sq_y;
    logic [32:0]        sq_z;
    logic signed [32:0] pn_x;
    logic signed [32:0] pn_y;
    logic signed [32:0] pn_z;
    logic [30:0]        cos_sq;
    logic [31:0]        maxd_sq;
    logic               cos_neg;
  } xf_t;

  // partial verdict after projection and distance tests
  typedef struct packed {
    reason_e     reason;
    logic        dot_neg;
    logic [34:0] dot_abs;
    logic [34:0] dist_sq;
    logic [30:0] cos_sq;
    logic        cos_neg;
  } pr_t;

endpackage

>>> hdl/fvt_xform.sv
`timescale 1ns / 1ps
// Stages A and B: rotation products, offset from the camera centre,
// then camera coordinates, squared offsets and dot-product terms.
module fvt_xform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fvt_pkg::point_t   point_i,
  input  fvt_pkg::cam_cfg_t cfg_i,
  output logic              valid_o,
  output fvt_pkg::xf_t      xf_o
);

  logic signed [15:0] p_w [3];
  logic signed [15:0] r_w [3][3];
  logic signed [15:0] t_w [3];
  logic signed [15:0] o_w [3];
  logic signed [15:0] n_w [3];

  logic signed [31:0] prod_d [3][3];
  logic signed [31:0] prod_q [3][3];
  logic signed [15:0] t_q [3];
  logic signed [16:0] po_d [3];
  logic signed [16:0] po_q [3];
  logic signed [15:0] n_q [3];
  logic [15:0]        maxd_q;
  logic signed [15:0] cosl_q;
  logic               va_q;

  logic signed [33:0] pc_d [3];
  logic signed [33:0] sqs_d [3];
  logic signed [32:0] pn_d [3];
  logic signed [31:0] cos2_d;
  logic [31:0]        maxd2_d;
  fvt_pkg::xf_t       xf_d;
  fvt_pkg::xf_t       xf_q;
  logic               vb_q;

  always_comb begin
    p_w[0] = point_i.point_x;
    p_w[1] = point_i.point_y;
    p_w[2] = point_i.point_z;
    n_w[0] = point_i.normal_x;
    n_w[1] = point_i.normal_y;
    n_w[2] = point_i.normal_z;
    r_w[0][0] = cfg_i.rot_row0[63:48];
    r_w[0][1] = cfg_i.rot_row0[47:32];
    r_w[0][2] = cfg_i.rot_row0[31:16];
    t_w[0]    = cfg_i.rot_row0[15:0];
    r_w[1][0] = cfg_i.rot_row1[63:48];
    r_w[1][1] = cfg_i.rot_row1[47:32];
    r_w[1][2] = cfg_i.rot_row1[31:16];
    t_w[1]    = cfg_i.rot_row1[15:0];
    r_w[2][0] = cfg_i.rot_row2[63:48];
    r_w[2][1] = cfg_i.rot_row2[47:32];
    r_w[2][2] = cfg_i.rot_row2[31:16];
    t_w[2]    = cfg_i.rot_row2[15:0];
    o_w[0] = cfg_i.camera_centre[47:32];
    o_w[1] = cfg_i.camera_centre[31:16];
    o_w[2] = cfg_i.camera_centre[15:0];
  end

  // stage A: nine rotation products and the offset P - O
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = r_w[i][j] * p_w[j];
      end
      po_d[i] = 17'(p_w[i]) - 17'(o_w[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      po_q   <= po_d;
      t_q    <= t_w;
      n_q    <= n_w;
      maxd_q <= point_i.max_distance;
      cosl_q <= point_i.cos_limit;
    end
  end

  // stage B: sums of rows, squares and normal terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc_d[i] = 34'(prod_q[i][0]) + 34'(prod_q[i][1]) + 34'(prod_q[i][2])
              + (34'(t_q[i]) <<< 14);
      sqs_d[i] = po_q[i] * po_q[i];
      pn_d[i]  = po_q[i] * n_q[i];
    end
    cos2_d  = cosl_q * cosl_q;
    maxd2_d = maxd_q * maxd_q;
    xf_d.pc_x    = pc_d[0];
    xf_d.pc_y    = pc_d[1];
    xf_d.pc_z    = pc_d[2];
    xf_d.sq_x    = sqs_d[0][32:0];
    xf_d.sq_y    = sqs_d[1][32:0];
    xf_d.sq_z    = sqs_d[2][32:0];
    xf_d.pn_x    = pn_d[0];
    xf_d.pn_y    = pn_d[1];
    xf_d.pn_z    = pn_d[2];
    xf_d.cos_sq  = cos2_d[30:0];
    xf_d.maxd_sq = maxd2_d;
    xf_d.cos_neg = cosl_q[15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xf_q <= xf_d;
    end
  end

  assign valid_o = vb_q;
  assign xf_o    = xf_q;

endmodule

>>> hdl/fvt_proj.sv
`timescale 1ns / 1ps
// Stages C and D: projection products, then the depth, image bound
// and distance tests.
module fvt_proj (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fvt_pkg::xf_t      xf_i,
  input  fvt_pkg::cam_cfg_t cfg_i,
  output logic              valid_o,
  output fvt_pkg::pr_t      pr_o
);

  logic signed [16:0] fx_w, fy_w, cx_w, cy_w;
  logic signed [16:0] minx_w, maxx_w, miny_w, maxy_w;

  logic signed [50:0] fxu_q, cxz_q, minx_q, maxx_q;
  logic signed [50:0] fyv_q, cyz_q, miny_q, maxy_q;
  logic               zpos_q;
  logic [34:0]        d2_q;
  logic signed [34:0] dot_q;
  logic [31:0]        maxd2_q;
  logic [30:0]        cos2_q;
  logic               cosneg_q;
  logic               vc_q;

  logic signed [51:0] u_w, v_w;
  fvt_pkg::pr_t       pr_d;
  fvt_pkg::pr_t       pr_q;
  logic               vd_q;

  always_comb begin
    fx_w   = $signed({1'b0, cfg_i.intrinsics[63:48]});
    fy_w   = $signed({1'b0, cfg_i.intrinsics[47:32]});
    cx_w   = $signed({1'b0, cfg_i.intrinsics[31:16]});
    cy_w   = $signed({1'b0, cfg_i.intrinsics[15:0]});
    minx_w = $signed({1'b0, cfg_i.image_bounds[63:48]});
    maxx_w = $signed({1'b0, cfg_i.image_bounds[47:32]});
    miny_w = $signed({1'b0, cfg_i.image_bounds[31:16]});
    maxy_w = $signed({1'b0, cfg_i.image_bounds[15:0]});
  end

  // stage C: eight projection products, distance and dot sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fxu_q    <= fx_w * xf_i.pc_x;
      cxz_q    <= cx_w * xf_i.pc_z;
      minx_q   <= minx_w * xf_i.pc_z;
      maxx_q   <= maxx_w * xf_i.pc_z;
      fyv_q    <= fy_w * xf_i.pc_y;
      cyz_q    <= cy_w * xf_i.pc_z;
      miny_q   <= miny_w * xf_i.pc_z;
      maxy_q   <= maxy_w * xf_i.pc_z;
      zpos_q   <= !xf_i.pc_z[33] && (xf_i.pc_z != '0);
      d2_q     <= 35'(xf_i.sq_x) + 35'(xf_i.sq_y) + 35'(xf_i.sq_z);
      dot_q    <= 35'(xf_i.pn_x) + 35'(xf_i.pn_y) + 35'(xf_i.pn_z);
      maxd2_q  <= xf_i.maxd_sq;
      cos2_q   <= xf_i.cos_sq;
      cosneg_q <= xf_i.cos_neg;
    end
  end

  // stage D: bound compares in priority order
  always_comb begin
    u_w = 52'(fxu_q) + 52'(cxz_q);
    v_w = 52'(fyv_q) + 52'(cyz_q);
    if (!zpos_q) begin
      pr_d.reason = fvt_pkg::RSN_DEPTH;
    end else if (u_w < 52'(minx_q) || u_w > 52'(maxx_q)) begin
      pr_d.reason = fvt_pkg::RSN_OUT_X;
    end else if (v_w < 52'(miny_q) || v_w > 52'(maxy_q)) begin
      pr_d.reason = fvt_pkg::RSN_OUT_Y;
    end else if (d2_q > 35'(maxd2_q)) begin
      pr_d.reason = fvt_pkg::RSN_DIST;
    end else begin
      pr_d.reason = fvt_pkg::RSN_NONE;
    end
    pr_d.dot_neg = dot_q[34];
    pr_d.dot_abs = dot_q[34] ? 35'(-dot_q) : 35'(dot_q);
    pr_d.dist_sq = d2_q;
    pr_d.cos_sq  = cos2_q;
    pr_d.cos_neg = cosneg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
    end
  end

  assign valid_o = vd_q;
  assign pr_o    = pr_q;

endmodule

>>> hdl/fvt_angle.sv
`timescale 1ns / 1ps
// Stages E and F: viewing cosine test on squares, split into partial
// products; stage F is the output register.
module fvt_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  fvt_pkg::pr_t        pr_i,
  output logic                valid_o,
  output fvt_pkg::result_t    res_o
);

  logic [35:0] ahh_q;
  logic [34:0] ahl_q;
  logic [33:0] all_q;
  logic [48:0] rdh_q;
  logic [47:0] rdl_q;
  fvt_pkg::reason_e reason_q;
  logic        dotneg_q;
  logic        cosneg_q;
  logic        d2nz_q;
  logic        ve_q;

  logic [71:0] lhs_w, rhs_w;
  fvt_pkg::reason_e reason_w;
  fvt_pkg::result_t res_q;
  logic        vf_q;

  // stage E: |dot|^2 and cos^2 * d2 as limb products split at bit 17
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ahh_q    <= pr_i.dot_abs[34:17] * pr_i.dot_abs[34:17];
      ahl_q    <= 35'(pr_i.dot_abs[34:17] * pr_i.dot_abs[16:0]);
      all_q    <= pr_i.dot_abs[16:0] * pr_i.dot_abs[16:0];
      rdh_q    <= pr_i.cos_sq * pr_i.dist_sq[34:17];
      rdl_q    <= pr_i.cos_sq * pr_i.dist_sq[16:0];
      reason_q <= pr_i.reason;
      dotneg_q <= pr_i.dot_neg;
      cosneg_q <= pr_i.cos_neg;
      d2nz_q   <= (pr_i.dist_sq != '0);
    end
  end

  // stage F: recombine and compare
  always_comb begin
    lhs_w = (72'(ahh_q) << 34) + (72'(ahl_q) << 18) + 72'(all_q);
    rhs_w = (72'(rdh_q) << 17) + 72'(rdl_q);
    reason_w = reason_q;
    if (reason_q == fvt_pkg::RSN_NONE && d2nz_q) begin
      if (!cosneg_q) begin
        if (dotneg_q || lhs_w < rhs_w) begin
          reason_w = fvt_pkg::RSN_ANGLE;
        end
      end else begin
        if (dotneg_q && lhs_w > rhs_w) begin
          reason_w = fvt_pkg::RSN_ANGLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.visible       <= (reason_w == fvt_pkg::RSN_NONE);
      res_q.reject_reason <= reason_w;
    end
  end

  assign valid_o = vf_q;
  assign res_o   = res_q;

endmodule

>>> hdl/frustum_visibility_test.sv
// Throughput: one point per cycle; the six-stage multiply pipeline
// advances as a whole and holds only while the output beat is stalled.
// Reset: asynchronous, active low; clears all stage valid bits and loads
// the identity rotation, zero translation, centre, intrinsics and bounds.
`timescale 1ns / 1ps
`include "frustum_visibility_test_macros.svh"
module frustum_visibility_test (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fvt_pkg::point_t                 in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fvt_pkg::result_t                out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fvt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);

  fvt_pkg::cam_cfg_t cfg_q;
  logic              en_w;
  logic              xf_valid, pr_valid;
  fvt_pkg::xf_t      xf_w;
  fvt_pkg::pr_t      pr_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_row0      <= fvt_pkg::ROT_ROW0_RST;
      cfg_q.rot_row1      <= fvt_pkg::ROT_ROW1_RST;
      cfg_q.rot_row2      <= fvt_pkg::ROT_ROW2_RST;
      cfg_q.camera_centre <= '0;
      cfg_q.intrinsics    <= '0;
      cfg_q.image_bounds  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fvt_pkg::CFG_ROT_ROW0:   cfg_q.rot_row0      <= cfg_data_i;
        fvt_pkg::CFG_ROT_ROW1:   cfg_q.rot_row1      <= cfg_data_i;
        fvt_pkg::CFG_ROT_ROW2:   cfg_q.rot_row2      <= cfg_data_i;
        fvt_pkg::CFG_CAM_CENTRE: cfg_q.camera_centre <= cfg_data_i[47:0];
        fvt_pkg::CFG_INTRINSICS: cfg_q.intrinsics    <= cfg_data_i;
        fvt_pkg::CFG_IMG_BOUNDS: cfg_q.image_bounds  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // whole pipeline moves unless the result beat is held
  assign en_w       = !out_valid_o || out_ready_i;
  assign in_ready_o = en_w;

  fvt_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (in_valid_i),
    .point_i (in_i),
    .cfg_i   (cfg_q),
    .valid_o (xf_valid),
    .xf_o    (xf_w)
  );

  fvt_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (xf_valid),
    .xf_i    (xf_w),
    .cfg_i   (cfg_q),
    .valid_o (pr_valid),
    .pr_o    (pr_w)
  );

  fvt_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (pr_valid),
    .pr_i    (pr_w),
    .valid_o (out_valid_o),
    .res_o   (out_o)
  );

  `FVT_ASSERT(a_vis_matches_reason, clk_i, rst_ni, out_valid_o |-> (out_o.visible == (out_o.reject_reason == fvt_pkg::RSN_NONE)), "visible flag disagrees with reason")
  `FVT_ASSERT(a_reason_range, clk_i, rst_ni, out_valid_o |-> (out_o.reject_reason <= fvt_pkg::RSN_ANGLE), "reason code out of range")
  `FVT_ASSERT(a_stall_ready, clk_i, rst_ni, (out_valid_o && !out_ready_i) |-> !in_ready_o, "input taken while result stalled")
  `FVT_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "result valid after a reset edge")

endmodule

>>> bench/tb_frustum_visibility_test.sv
`timescale 1ns / 1ps
module tb_frustum_visibility_test;

  localparam int HoldCycles = 300;
  localparam int WdogLimit  = 3000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  fvt_pkg::point_t             in_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  fvt_pkg::result_t            out_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [fvt_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0]                 cfg_data_i = '0;

  frustum_visibility_test u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i,
    .out_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // camera settings as the block should hold them
  logic [63:0] cam_rot [3];
  logic [47:0] cam_ctr;
  logic [63:0] cam_intr;
  logic [63:0] cam_bnds;

  fvt_pkg::result_t verdict_q [$];
  bit               beat_typed = 1'b0;
  fvt_pkg::result_t beat_verdict = '0;
  int               errors = 0;
  int               points_sent = 0;
  int               verdicts_seen = 0;
  int               reason_hits [8];
  bit               long_hold = 1'b0;

  // exact visibility verdict for one point under the current camera
  function automatic fvt_pkg::result_t predict_visibility(fvt_pkg::point_t p);
    longint pt [3];
    longint nv [3];
    longint pc [3];
    longint po [3];
    longint fx, fy, cx, cy, minx, maxx, miny, maxy, z, u, v, dot, cosl;
    longint unsigned d2, md, ad, ac;
    logic [127:0] lhs, rhs;
    fvt_pkg::reason_e rsn;
    fvt_pkg::result_t res;
    pt[0] = $signed(p.point_x);
    pt[1] = $signed(p.point_y);
    pt[2] = $signed(p.point_z);
    nv[0] = $signed(p.normal_x);
    nv[1] = $signed(p.normal_y);
    nv[2] = $signed(p.normal_z);
    cosl  = $signed(p.cos_limit);
    for (int i = 0; i < 3; i++) begin
      pc[i] = $signed(cam_rot[i][63:48]) * pt[0] + $signed(cam_rot[i][47:32]) * pt[1]
            + $signed(cam_rot[i][31:16]) * pt[2] + $signed(cam_rot[i][15:0]) * 64'sd16384;
    end
    rsn = fvt_pkg::RSN_NONE;
    if (pc[2] <= 0) begin
      rsn = fvt_pkg::RSN_DEPTH;
    end else begin
      fx = cam_intr[63:48]; fy = cam_intr[47:32];
      cx = cam_intr[31:16]; cy = cam_intr[15:0];
      minx = cam_bnds[63:48]; maxx = cam_bnds[47:32];
      miny = cam_bnds[31:16]; maxy = cam_bnds[15:0];
      z = pc[2];
      u = fx * pc[0] + cx * z;
      v = fy * pc[1] + cy * z;
      if (u < minx * z || u > maxx * z) begin
        rsn = fvt_pkg::RSN_OUT_X;
      end else if (v < miny * z || v > maxy * z) begin
        rsn = fvt_pkg::RSN_OUT_Y;
      end else begin
        po[0] = pt[0] - longint'($signed(cam_ctr[47:32]));
        po[1] = pt[1] - longint'($signed(cam_ctr[31:16]));
        po[2] = pt[2] - longint'($signed(cam_ctr[15:0]));
        d2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
          d2 += longint'(po[i] * po[i]);
          dot += po[i] * nv[i];
        end
        md = p.max_distance;
        if (d2 > md * md) begin
          rsn = fvt_pkg::RSN_DIST;
        end else if (d2 != 0) begin
          // compare dot^2 with cos^2 * d2, signs decide the direction
          ad = (dot < 0) ? -dot : dot;
          ac = (cosl < 0) ? -cosl : cosl;
          lhs = {64'd0, ad} * {64'd0, ad};
          rhs = {64'd0, ac * ac} * {64'd0, d2};
          if (cosl >= 0) begin
            if (dot < 0 || lhs < rhs) rsn = fvt_pkg::RSN_ANGLE;
          end else begin
            if (dot < 0 && lhs > rhs) rsn = fvt_pkg::RSN_ANGLE;
          end
        end
      end
    end
    res.visible = (rsn == fvt_pkg::RSN_NONE);
    res.reject_reason = rsn;
    return res;
  endfunction

  // input and output beat bookkeeping, compare against oldest verdict
  always @(posedge clk_i) begin
    fvt_pkg::result_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      verdict_q.push_back(beat_typed ? beat_verdict : predict_visibility(in_i));
      points_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      verdicts_seen++;
      reason_hits[out_o.reject_reason]++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat %0h with nothing pending", out_o);
      end else begin
        want = verdict_q.pop_front();
        if (out_o.visible !== want.visible || out_o.reject_reason !== want.reject_reason) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: verdict mismatch: exp vis=%0b rsn=%0d got vis=%0b rsn=%0d",
                     want.visible, want.reject_reason, out_o.visible, out_o.reject_reason);
        end
      end
    end
  end

  // receiver: segments of always ready, random, mostly stalled; long hold on request
  initial begin
    int mode, seg, held;
    forever begin
      mode = $urandom_range(0, 2);
      seg = $urandom_range(20, 120);
      for (int i = 0; i < seg; i++) begin
        @(negedge clk_i);
        if (long_hold) begin
          out_ready_i = 1'b0;
          for (held = 0; held < HoldCycles; held++) @(negedge clk_i);
          long_hold = 1'b0;
        end
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= WdogLimit) begin
        $display("ERROR: timeout, no beat for %0d cycles", WdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // drive one point beat; entered and left at a falling edge, valid left high
  task automatic send_point(fvt_pkg::point_t p, bit typed, fvt_pkg::result_t res);
    in_i = p;
    beat_typed = typed;
    beat_verdict = res;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_verdicts();
    in_valid_i = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [fvt_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fvt_pkg::CFG_ROT_ROW0:   cam_rot[0] = data;
      fvt_pkg::CFG_ROT_ROW1:   cam_rot[1] = data;
      fvt_pkg::CFG_ROT_ROW2:   cam_rot[2] = data;
      fvt_pkg::CFG_CAM_CENTRE: cam_ctr = data[47:0];
      fvt_pkg::CFG_INTRINSICS: cam_intr = data;
      fvt_pkg::CFG_IMG_BOUNDS: cam_bnds = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic fvt_pkg::point_t mk_point(logic [15:0] px, logic [15:0] py,
                                               logic [15:0] pz, logic [15:0] nx,
                                               logic [15:0] ny, logic [15:0] nz,
                                               logic [15:0] md, logic [15:0] cl);
    fvt_pkg::point_t p;
    p = {px, py, pz, nx, ny, nz, md, cl};
    return p;
  endfunction

  // mostly plausible points in front of the camera, some pure noise
  function automatic fvt_pkg::point_t rand_point();
    fvt_pkg::point_t p;
    int pick;
    pick = $urandom_range(0, 19);
    p = fvt_pkg::point_t'({$urandom, $urandom, $urandom, $urandom});
    if (pick < 14) begin
      p.point_x = 16'($signed($urandom_range(0, 16'h1000)) - 16'sh0800);
      p.point_y = 16'($signed($urandom_range(0, 16'h1000)) - 16'sh0800);
      p.point_z = 16'($urandom_range(16'h0040, 16'h2000));
      p.normal_x = 16'($signed($urandom_range(0, 16'h8000)) - 16'sh4000);
      p.normal_y = 16'($signed($urandom_range(0, 16'h8000)) - 16'sh4000);
      p.normal_z = 16'($signed($urandom_range(0, 16'h8000)) - 16'sh4000);
      p.max_distance = 16'($urandom_range(0, 16'h3000));
      p.cos_limit = 16'($signed($urandom_range(0, 16'h8000)) - 16'sh4000);
    end else if (pick == 14) begin
      {p.point_x, p.point_y, p.point_z} = cam_ctr;
    end
    return p;
  endfunction

  task automatic random_points(int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_point(rand_point(), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  typedef struct {
    fvt_pkg::point_t  pt;
    bit               typed;
    fvt_pkg::result_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    fvt_pkg::result_t none_r;
    cam_rot[0] = fvt_pkg::ROT_ROW0_RST;
    cam_rot[1] = fvt_pkg::ROT_ROW1_RST;
    cam_rot[2] = fvt_pkg::ROT_ROW2_RST;
    cam_ctr = '0;
    cam_intr = '0;
    cam_bnds = '0;
    none_r = '0;
    foreach (reason_hits[i]) reason_hits[i] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed points under the reset camera: identity, zero intrinsics and bounds
    rows.push_back('{mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b0, fvt_pkg::RSN_DEPTH}});
    rows.push_back('{mk_point(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'hffff, 16'h7fff), 1, '{1'b0, fvt_pkg::RSN_DEPTH}});
    rows.push_back('{mk_point(0, 0, 1, 0, 0, 0, 0, 0), 1, '{1'b0, fvt_pkg::RSN_DIST}});
    rows.push_back('{mk_point(0, 0, 1, 0, 0, 0, 1, 0), 1, '{1'b1, fvt_pkg::RSN_NONE}});
    rows.push_back('{mk_point(0, 0, 1, 0, 0, 0, 1, 1), 1, '{1'b0, fvt_pkg::RSN_ANGLE}});
    rows.push_back('{mk_point(0, 0, 16'h0100, 0, 0, 16'hc000, 16'hffff, 0), 1,
                     '{1'b0, fvt_pkg::RSN_ANGLE}});
    rows.push_back('{mk_point(0, 0, 16'h0100, 0, 0, 16'hc000, 16'hffff, 16'hc000), 0, none_r});
    rows.push_back('{mk_point(0, 0, 16'h0100, 0, 0, 16'hc000, 16'hffff, 16'hc001), 0, none_r});
    rows.push_back('{mk_point(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'hffff, 16'h8000), 0, none_r});
    rows.push_back('{mk_point(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                              16'hffff, 16'h7fff), 0, none_r});
    rows.push_back('{mk_point(16'h0010, 16'hfff0, 16'h0200, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'h0400, 16'h4000), 0, none_r});
    rows.push_back('{mk_point(16'h0010, 16'hfff0, 16'h0200, 16'h4000, 0, 16'h4000,
                              16'h0400, 16'h8000), 0, none_r});
    rows.push_back('{mk_point(16'h0100, 16'h0100, 16'h0100, 16'h2d41, 16'h2d41, 0,
                              16'h01bb, 16'h2d41), 0, none_r});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].res);
    drain_verdicts();

    // wide camera: identity rotation pushed forward, centered principal point
    write_cfg(fvt_pkg::CFG_ROT_ROW0, {16'h4000, 16'h0000, 16'h0000, 16'h0040});
    write_cfg(fvt_pkg::CFG_ROT_ROW1, {16'h0000, 16'h4000, 16'h0000, 16'hffc0});
    write_cfg(fvt_pkg::CFG_ROT_ROW2, {16'h0000, 16'h0000, 16'h4000, 16'h0200});
    write_cfg(fvt_pkg::CFG_CAM_CENTRE, {16'h0000, 16'h0000, 16'hfe00});
    write_cfg(fvt_pkg::CFG_INTRINSICS, {16'h0100, 16'h0100, 16'h8000, 16'h8000});
    write_cfg(fvt_pkg::CFG_IMG_BOUNDS, {16'h0000, 16'hffff, 16'h0000, 16'hffff});
    // point at the camera centre has zero distance
    send_point(mk_point(16'h0000, 16'h0000, 16'hfe00, 16'h1234, 0, 0, 0, 16'h7fff), 0, none_r);
    random_points(300);
    // long receiver hold while points keep coming
    long_hold = 1'b1;
    random_points(80);
    drain_verdicts();

    // narrow image so x and y tests bite
    write_cfg(fvt_pkg::CFG_IMG_BOUNDS, {16'h6000, 16'ha000, 16'h7000, 16'h9000});
    random_points(300);
    drain_verdicts();

    // random rotations, centres, intrinsics and bounds
    for (int k = 0; k < 4; k++) begin
      write_cfg(fvt_pkg::CFG_ROT_ROW0, {16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom)});
      write_cfg(fvt_pkg::CFG_ROT_ROW1, {16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom)});
      write_cfg(fvt_pkg::CFG_ROT_ROW2, {16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h8000) - 16'h4000),
                                        16'($urandom_range(0, 16'h7fff))});
      write_cfg(fvt_pkg::CFG_CAM_CENTRE, {$urandom, $urandom});
      write_cfg(fvt_pkg::CFG_INTRINSICS, {$urandom, $urandom});
      write_cfg(fvt_pkg::CFG_IMG_BOUNDS, {16'($urandom_range(0, 16'h7fff)),
                                          16'($urandom_range(16'h8000, 16'hffff)),
                                          16'($urandom_range(0, 16'h7fff)),
                                          16'($urandom_range(16'h8000, 16'hffff))});
      random_points(150);
      drain_verdicts();
    end

    // extremes: all ones in rotation, centre and intrinsics, unused indexes must be ignored
    write_cfg(fvt_pkg::CFG_ROT_ROW0, '1);
    write_cfg(fvt_pkg::CFG_ROT_ROW1, '1);
    write_cfg(fvt_pkg::CFG_ROT_ROW2, '1);
    write_cfg(fvt_pkg::CFG_CAM_CENTRE, '1);
    write_cfg(fvt_pkg::CFG_INTRINSICS, '1);
    write_cfg(fvt_pkg::CFG_IMG_BOUNDS, {16'h0000, 16'hffff, 16'h0000, 16'hffff});
    write_cfg(3'd6, '0);
    write_cfg(3'd7, '0);
    random_points(100);
    drain_verdicts();
    // all zero camera: every point fails on depth
    write_cfg(fvt_pkg::CFG_ROT_ROW0, '0);
    write_cfg(fvt_pkg::CFG_ROT_ROW1, '0);
    write_cfg(fvt_pkg::CFG_ROT_ROW2, '0);
    write_cfg(fvt_pkg::CFG_CAM_CENTRE, '0);
    write_cfg(fvt_pkg::CFG_INTRINSICS, '0);
    write_cfg(fvt_pkg::CFG_IMG_BOUNDS, '0);
    random_points(50);
    drain_verdicts();
    // most negative third rotation row and centre, most positive z translation
    write_cfg(fvt_pkg::CFG_ROT_ROW2, {16'h8000, 16'h8000, 16'h8000, 16'h7fff});
    write_cfg(fvt_pkg::CFG_CAM_CENTRE, {16'h8000, 16'h8000, 16'h8000});
    random_points(50);

    drain_verdicts();
    repeat (20) @(negedge clk_i);
    $display("Run: %0d points, %0d verdicts checked, %0d mismatches", points_sent,
             verdicts_seen, errors);
    $display("Reasons seen: none %0d depth %0d x %0d y %0d distance %0d angle %0d",
             reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3],
             reason_hits[4], reason_hits[5]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/fvt_pkg.sv
hdl/fvt_xform.sv
hdl/fvt_proj.sv
hdl/fvt_angle.sv
hdl/frustum_visibility_test.sv
bench/tb_frustum_visibility_test.sv
